// ===== src/dtq_pkg.sv =====
// Shared types and constants for the deadline timer queue.
`default_nettype none
package dtq_pkg;

  localparam int TIME_W    = 63;
  localparam int IVL_W     = 31;
  localparam int ID_W      = 32;
  localparam int MS_W      = 20;
  localparam int PROD_W    = IVL_W + MS_W;
  localparam int MAX_RES   = 16;
  localparam int RES_IDX_W = 4;
  localparam int CNT_W     = 5;

  localparam logic [MS_W-1:0] NS_PER_MS = MS_W'(1000000);

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [IVL_W-1:0]  interval;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic sweep_start;
    logic sweep_due;
    logic write_new;
    logic set_err;
    logic take;
    logic rearm_mul;
    logic rearm_wr;
    logic k_inc;
    logic k_clear;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic sweep_busy;
    logic free_found;
    logic best_found;
    logic pop_full;
    logic pop_empty;
    logic k_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== src/dtq_if.sv =====
// Request and result channel interfaces of the deadline timer queue.
`default_nettype none
interface dtq_in_if import dtq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [TIME_W-1:0] time_value;
  logic [IVL_W-1:0]  repeat_ms;

  modport source(output valid, operation, time_value, repeat_ms, input ready);
  modport sink(input valid, operation, time_value, repeat_ms, output ready);
endinterface

interface dtq_out_if import dtq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              expired_valid;
  logic [ID_W-1:0]   expired_id;
  logic [TIME_W-1:0] next_deadline;
  logic              armed;
  logic              full_error;
  logic              last_result;

  modport source(output valid, expired_valid, expired_id, next_deadline, armed, full_error,
                 last_result, input ready);
  modport sink(input valid, expired_valid, expired_id, next_deadline, armed, full_error,
               last_result, output ready);
endinterface
`default_nettype wire

// ===== src/dtq_ctrl.sv =====
// Sequencing state machine of the deadline timer queue.
`default_nettype none
module dtq_ctrl import dtq_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    req_valid,
  input  wire logic    req_operation,
  output logic         req_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_A_WAIT = 3'd1;
  localparam logic [2:0] S_T_WAIT = 3'd2;
  localparam logic [2:0] S_R_RD   = 3'd3;
  localparam logic [2:0] S_R_MUL  = 3'd4;
  localparam logic [2:0] S_R_WR   = 3'd5;
  localparam logic [2:0] S_F_WAIT = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  localparam logic OP_TICK = 1'b1;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept      = 1'b1;
          cmd.sweep_start = 1'b1;
          cmd.sweep_due   = (req_operation == OP_TICK);
          state_next      = (req_operation == OP_TICK) ? S_T_WAIT : S_A_WAIT;
        end
      end
      S_A_WAIT: begin
        if (!status.sweep_busy) begin
          if (status.free_found) begin
            cmd.write_new   = 1'b1;
            cmd.sweep_start = 1'b1;
            state_next      = S_F_WAIT;
          end else begin
            cmd.set_err = 1'b1;
            state_next  = S_EMIT;
          end
        end
      end
      S_T_WAIT: begin
        if (!status.sweep_busy) begin
          if (status.best_found && !status.pop_full) begin
            cmd.take        = 1'b1;
            cmd.sweep_start = 1'b1;
            cmd.sweep_due   = 1'b1;
          end else if (status.pop_empty) begin
            cmd.sweep_start = 1'b1;
            state_next      = S_F_WAIT;
          end else begin
            state_next = S_R_RD;
          end
        end
      end
      S_R_RD: begin
        state_next = S_R_MUL;
      end
      S_R_MUL: begin
        cmd.rearm_mul = 1'b1;
        state_next    = S_R_WR;
      end
      S_R_WR: begin
        cmd.rearm_wr = 1'b1;
        if (status.k_last) begin
          cmd.k_clear     = 1'b1;
          cmd.sweep_start = 1'b1;
          state_next      = S_F_WAIT;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_R_RD;
        end
      end
      S_F_WAIT: begin
        if (!status.sweep_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.pop_empty || status.k_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.k_inc = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/dtq_datapath.sv =====
// Timer table, sweep comparator, pop list, re-arm arithmetic and result register.
`default_nettype none
module dtq_datapath import dtq_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int IW   = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output status_t                status,
  input  wire logic [TIME_W-1:0] req_time_value,
  input  wire logic [IVL_W-1:0]  req_repeat_ms,
  input  wire logic              res_ready,
  output logic                   res_valid,
  output logic                   res_expired_valid,
  output logic [ID_W-1:0]        res_expired_id,
  output logic [TIME_W-1:0]      res_next_deadline,
  output logic                   res_armed,
  output logic                   res_full_error,
  output logic                   res_last_result
);

  entry_t            table_mem [DEPTH];
  entry_t            rd_data;
  logic [IW-1:0]     rd_addr;
  logic [DEPTH-1:0]  valid;
  logic [DEPTH-1:0]  taken;
  logic [ID_W-1:0]   seq;
  logic [TIME_W-1:0] now_time;
  logic [IVL_W-1:0]  new_interval;
  logic              err;

  logic              sw_run;
  logic              sw_due;
  logic [IW-1:0]     sw_addr;
  logic              sw_dv;
  logic [IW-1:0]     sw_didx;
  logic              best_found;
  logic [IW-1:0]     best_idx;
  logic [TIME_W-1:0] best_deadline;
  logic [ID_W-1:0]   best_id;
  logic              free_found;
  logic [IW-1:0]     free_idx;

  logic [IW-1:0]     pop_idx [MAX_RES];
  logic [ID_W-1:0]   pop_id [MAX_RES];
  logic [CNT_W-1:0]  pop_count;
  logic [RES_IDX_W-1:0] k;
  logic [PROD_W-1:0] prod;

  logic              cand_ok;
  logic              cand_earlier;
  logic [TIME_W:0]   rearm_sum;
  logic [TIME_W-1:0] rearm_deadline;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;
  logic              k_last;
  logic              pop_empty;

  assign rd_addr = sw_run ? sw_addr : pop_idx[k];

  assign cand_ok = valid[sw_didx] &&
                   (!sw_due || (!taken[sw_didx] && (rd_data.deadline <= now_time)));
  assign cand_earlier = !best_found || (rd_data.deadline < best_deadline) ||
                        ((rd_data.deadline == best_deadline) && (rd_data.id < best_id));

  assign rearm_sum      = {1'b0, rd_data.deadline} + (TIME_W + 1)'(prod);
  assign rearm_deadline = rearm_sum[TIME_W] ? '1 : rearm_sum[TIME_W-1:0];

  assign pop_empty = (pop_count == '0);
  assign k_last    = ({1'b0, k} == (pop_count - CNT_W'(1)));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = free_idx;
    wr_data = '{deadline: now_time, interval: new_interval, id: seq + ID_W'(1)};
    if (cmd.write_new) begin
      wr_en = 1'b1;
    end else if (cmd.rearm_wr && (rd_data.interval != '0)) begin
      wr_en   = 1'b1;
      wr_addr = pop_idx[k];
      wr_data = '{deadline: rearm_deadline, interval: rd_data.interval, id: rd_data.id};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_data <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      taken     <= '0;
      seq       <= '0;
      err       <= 1'b0;
      sw_run    <= 1'b0;
      sw_dv     <= 1'b0;
      pop_count <= '0;
      k         <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        taken     <= '0;
        err       <= 1'b0;
        pop_count <= '0;
        k         <= '0;
      end
      if (cmd.write_new) begin
        valid[free_idx] <= 1'b1;
        seq             <= seq + ID_W'(1);
      end
      if (cmd.rearm_wr && (rd_data.interval == '0)) begin
        valid[pop_idx[k]] <= 1'b0;
      end
      if (cmd.set_err) begin
        err <= 1'b1;
      end
      if (cmd.take) begin
        taken[best_idx] <= 1'b1;
        pop_count       <= pop_count + CNT_W'(1);
      end
      if (cmd.k_clear) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k + RES_IDX_W'(1);
      end
      if (cmd.sweep_start) begin
        sw_run <= 1'b1;
      end else if (sw_run && (sw_addr == IW'(DEPTH - 1))) begin
        sw_run <= 1'b0;
      end
      sw_dv <= sw_run;
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_time     <= req_time_value;
      new_interval <= req_repeat_ms;
    end
    if (cmd.sweep_start) begin
      sw_addr    <= '0;
      sw_due     <= cmd.sweep_due;
      best_found <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (sw_run) begin
        sw_addr <= sw_addr + IW'(1);
      end
      if (sw_dv) begin
        if (cand_ok && cand_earlier) begin
          best_found    <= 1'b1;
          best_idx      <= sw_didx;
          best_deadline <= rd_data.deadline;
          best_id       <= rd_data.id;
        end
        if (!valid[sw_didx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= sw_didx;
        end
      end
    end
    sw_didx <= sw_addr;
    if (cmd.take) begin
      pop_idx[pop_count[RES_IDX_W-1:0]] <= best_idx;
      pop_id[pop_count[RES_IDX_W-1:0]]  <= best_id;
    end
    if (cmd.rearm_mul) begin
      prod <= PROD_W'(rd_data.interval) * PROD_W'(NS_PER_MS);
    end
    if (cmd.emit) begin
      res_expired_valid <= !pop_empty;
      res_expired_id    <= pop_empty ? '0 : pop_id[k];
      res_next_deadline <= best_found ? best_deadline : '0;
      res_armed         <= best_found;
      res_full_error    <= err;
      res_last_result   <= pop_empty || k_last;
    end
  end

  always_comb begin
    status            = '0;
    status.sweep_busy = sw_run || sw_dv;
    status.free_found = free_found;
    status.best_found = best_found;
    status.pop_full   = (pop_count == CNT_W'(MAX_RES));
    status.pop_empty  = pop_empty;
    status.k_last     = k_last;
    status.out_free   = !res_valid || res_ready;
  end

endmodule
`default_nettype wire

// ===== src/deadline_timer_queue.sv =====
// Top level of the deadline timer queue: controller, datapath and channel wiring.
//
// The queue holds up to DEPTH timers in a table with one read and one write port and finds
// the earliest entry by sweeping the table one entry per cycle. An add beat that finds a free
// slot takes two sweeps before its result; a refused add takes one sweep. A tick that pops
// P timers takes P + 2 sweeps and a re-arm read, multiply and write per popped timer, then
// delivers its P results (one when nothing is due) on consecutive cycles while the result
// channel is ready. A new request beat is taken once the last result of the previous one is
// in the output register. No timer ever expires twice on one tick, at most sixteen are
// popped per tick, and re-armed deadlines saturate at the largest 63-bit value.
`default_nettype none
module deadline_timer_queue import dtq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  dtq_in_if.sink    request,
  dtq_out_if.source result
);

  cmd_t    cmd;
  status_t status;
  logic    req_ready;

  assign request.ready = req_ready;

  dtq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (request.valid),
    .req_operation(request.operation),
    .req_ready    (req_ready),
    .status       (status),
    .cmd          (cmd)
  );

  dtq_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .req_time_value   (request.time_value),
    .req_repeat_ms    (request.repeat_ms),
    .res_ready        (result.ready),
    .res_valid        (result.valid),
    .res_expired_valid(result.expired_valid),
    .res_expired_id   (result.expired_id),
    .res_next_deadline(result.next_deadline),
    .res_armed        (result.armed),
    .res_full_error   (result.full_error),
    .res_last_result  (result.last_result)
  );

endmodule
`default_nettype wire

// ===== src/dtq_checker.sv =====
// Port-level assertions for the deadline timer queue and their bind.
`default_nettype none
module dtq_checker import dtq_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              res_valid,
  input wire logic              res_ready,
  input wire logic              expired_valid,
  input wire logic [ID_W-1:0]   expired_id,
  input wire logic [TIME_W-1:0] next_deadline,
  input wire logic              armed,
  input wire logic              full_error,
  input wire logic              last_result
);

  // A refused add leaves a full table behind, so it reports an armed queue.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && full_error) |-> (armed && last_result && !expired_valid))
    else $error("full_error beat is inconsistent");

  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !armed) |-> (next_deadline == '0))
    else $error("empty queue reports a nonzero deadline");

  // A beat without an expired timer is always the only result of its request.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !expired_valid) |-> (last_result && (expired_id == '0)))
    else $error("non-expiry beat is not a lone final beat");

  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(expired_id) &&
                                   $stable(last_result) && $stable(next_deadline)))
    else $error("stalled result beat changed");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .expired_valid(result.expired_valid),
  .expired_id   (result.expired_id),
  .next_deadline(result.next_deadline),
  .armed        (result.armed),
  .full_error   (result.full_error),
  .last_result  (result.last_result)
);
`default_nettype wire
